// File: src/lcsld_pkg.sv
// Shared constants, operation codes and controller/datapath interface types
// for the LCS and edit-distance similarity block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcsld_pkg;

  // Longest string that is kept, and the number of symbol bits that take part in compares.
  localparam int MAX_LEN     = 256;
  localparam int SYMBOL_BITS = 16;

  // Width of the symbol port and of a stored symbol.
  localparam int SYM_IN_W = 16;
  localparam int SYM_W    = (SYMBOL_BITS < SYM_IN_W) ? SYMBOL_BITS : SYM_IN_W;

  // Lengths and row values lie in 0..MAX_LEN.
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Fixed-point similarity: 16 fraction bits, 1.0 is representable.
  localparam int FRAC_BITS = 16;
  localparam int SIM_W     = FRAC_BITS + 1;
  localparam int SUM_W     = LEN_W + 1;
  localparam int DVD_W     = LEN_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DVD_W + 1);

  // Operation codes on the op field.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_first;
    logic flag_ovf;
    logic row_start;
    logic row_run;
    logic row_end;
    logic fin_read;
    logic div_start;
    logic div_run;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic second_started;
    logic first_full;
    logic second_full;
    logic row_done;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// File: src/lcsld_ctrl.sv
// Controller state machine for the similarity block: sequences appends, row
// updates, the final read and the divider. Depends on lcsld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcsld_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [lcsld_pkg::OP_W-1:0] op,
  input  wire logic                     out_free,
  output logic                          out_load,
  input  wire lcsld_pkg::status_t       status,
  output lcsld_pkg::cmd_t               cmd
);
  import lcsld_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROW    = 3'd1;
  localparam logic [2:0] S_FIN_RD = 3'd2;
  localparam logic [2:0] S_FIN_LD = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Items are taken only between operations.
  assign in_stall = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_FIRST: begin
              if (!status.second_started) begin
                if (status.first_full) begin
                  cmd.flag_ovf = 1'b1;
                end else begin
                  cmd.store_first = 1'b1;
                end
              end
            end
            OP_SECOND: begin
              if (status.second_full) begin
                cmd.flag_ovf = 1'b1;
              end else begin
                cmd.row_start = 1'b1;
                state_next    = S_ROW;
              end
            end
            OP_FINISH: begin
              state_next = S_FIN_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROW: begin
        if (status.row_done) begin
          cmd.row_end = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.row_run = 1'b1;
        end
      end
      S_FIN_RD: begin
        cmd.fin_read = 1'b1;
        state_next   = S_FIN_LD;
      end
      S_FIN_LD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_OUT;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: src/lcsld_dpath.sv
// Datapath of the similarity block: stored first string, the LCS and distance
// rows, the cell update and a restoring divider. Depends on lcsld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcsld_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [lcsld_pkg::SYM_IN_W-1:0]  symbol,
  input  wire lcsld_pkg::cmd_t                 cmd,
  output lcsld_pkg::status_t                   status,
  output logic [lcsld_pkg::LEN_W-1:0]          res_lcs,
  output logic [lcsld_pkg::LEN_W-1:0]          res_dist,
  output logic [lcsld_pkg::SIM_W-1:0]          res_sim,
  output logic                                 res_empty,
  output logic                                 res_ovf
);
  import lcsld_pkg::*;

  // Row entries 1..MAX_LEN live at memory address i-1; entry 0 is implied:
  // its LCS value is zero and its distance equals the second length.
  logic [SYM_W-1:0] mem_sym  [MAX_LEN];
  logic [LEN_W-1:0] mem_lcs  [MAX_LEN];
  logic [LEN_W-1:0] mem_dist [MAX_LEN];

  logic [LEN_W-1:0] first_length;
  logic [LEN_W-1:0] second_length;
  logic             overflow_seen;

  logic [SYM_W-1:0] cur_sym;
  logic [LEN_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             cell_pend;
  logic [LEN_W-1:0] left_lcs;
  logic [LEN_W-1:0] left_dist;
  logic [LEN_W-1:0] diag_lcs;
  logic [LEN_W-1:0] diag_dist;

  logic [SYM_W-1:0] rd_sym;
  logic [LEN_W-1:0] rd_lcs;
  logic [LEN_W-1:0] rd_dist;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rem;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  quo;
  logic [DCNT_W-1:0] div_cnt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] fin_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [LEN_W-1:0] wr_lcs;
  logic [LEN_W-1:0] wr_dist;
  logic [LEN_W-1:0] first_plus;

  logic             same;
  logic [LEN_W-1:0] lcs_new;
  logic [LEN_W:0]   up_p1;
  logic [LEN_W:0]   left_p1;
  logic [LEN_W:0]   diag_p;
  logic [LEN_W:0]   min_a;
  logic [LEN_W-1:0] dist_new;

  logic             n_zero;
  logic [LEN_W-1:0] fin_lcs;
  logic [LEN_W-1:0] fin_dist;
  logic [SUM_W:0]   rem_sh;
  logic [SUM_W:0]   rem_sub;

  // Status toward the controller.
  assign n_zero                = (first_length == '0);
  assign status.second_started = (second_length != '0);
  assign status.first_full     = (first_length == LEN_W'(MAX_LEN));
  assign status.second_full    = (second_length == LEN_W'(MAX_LEN));
  assign status.row_done       = (rd_idx == first_length) && !cell_pend;
  assign status.div_done       = (div_cnt == '0);

  // One cell of both rows: up values come from memory, left from the cell
  // just computed, diagonal from the previous up values.
  always_comb begin
    same    = (rd_sym == cur_sym);
    if (same) begin
      lcs_new = diag_lcs + LEN_W'(1);
    end else begin
      lcs_new = (rd_lcs > left_lcs) ? rd_lcs : left_lcs;
    end
    up_p1    = {1'b0, rd_dist} + (LEN_W+1)'(1);
    left_p1  = {1'b0, left_dist} + (LEN_W+1)'(1);
    diag_p   = {1'b0, diag_dist} + (LEN_W+1)'(same ? 1'b0 : 1'b1);
    min_a    = (up_p1 < left_p1) ? up_p1 : left_p1;
    dist_new = (min_a < diag_p) ? min_a[LEN_W-1:0] : diag_p[LEN_W-1:0];
  end

  // Memory port selection: one read and one write address per cycle.
  assign first_plus = first_length + LEN_W'(1);
  assign fin_addr   = IDX_W'(first_length - LEN_W'(1));
  assign rd_en      = cmd.fin_read || (cmd.row_run && (rd_idx < first_length));
  assign rd_addr    = cmd.fin_read ? fin_addr : rd_idx[IDX_W-1:0];
  assign wr_en      = cmd.store_first || cell_pend;
  assign wr_addr    = cmd.store_first ? first_length[IDX_W-1:0] : wr_idx;
  assign wr_lcs     = cmd.store_first ? '0 : lcs_new;
  assign wr_dist    = cmd.store_first ? first_plus : dist_new;

  // Symbol store, written only on first-string appends.
  always_ff @(posedge clk) begin
    if (cmd.store_first) begin
      mem_sym[first_length[IDX_W-1:0]] <= symbol[SYM_W-1:0];
    end
  end

  // Row memories.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lcs[wr_addr]  <= wr_lcs;
      mem_dist[wr_addr] <= wr_dist;
    end
  end

  // Registered read of all three memories.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sym  <= mem_sym[rd_addr];
      rd_lcs  <= mem_lcs[rd_addr];
      rd_dist <= mem_dist[rd_addr];
    end
  end

  // Lengths and the overflow flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.store_first) begin
        first_length <= first_plus;
      end
      if (cmd.row_end) begin
        second_length <= second_length + LEN_W'(1);
      end
      if (cmd.flag_ovf) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Row sweep control: read index and the pending-cell marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      cell_pend <= 1'b0;
    end else if (cmd.row_start) begin
      rd_idx    <= '0;
      cell_pend <= 1'b0;
    end else if (cmd.row_run) begin
      if (rd_idx < first_length) begin
        rd_idx    <= rd_idx + LEN_W'(1);
        cell_pend <= 1'b1;
      end else begin
        cell_pend <= 1'b0;
      end
    end else begin
      cell_pend <= 1'b0;
    end
  end

  // Row sweep data: symbol, write address, left and diagonal neighbors.
  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      cur_sym   <= symbol[SYM_W-1:0];
      left_lcs  <= '0;
      left_dist <= second_length + LEN_W'(1);
      diag_lcs  <= '0;
      diag_dist <= second_length;
    end else begin
      if (cmd.row_run && (rd_idx < first_length)) begin
        wr_idx <= rd_idx[IDX_W-1:0];
      end
      if (cell_pend) begin
        left_lcs  <= lcs_new;
        left_dist <= dist_new;
        diag_lcs  <= rd_lcs;
        diag_dist <= rd_dist;
      end
    end
  end

  // Final row values; an empty first string leaves only entry 0.
  assign fin_lcs  = n_zero ? '0 : rd_lcs;
  assign fin_dist = n_zero ? second_length : rd_dist;

  // Restoring divider, one quotient bit per cycle.
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DCNT_W'(DVD_W);
    end else if (cmd.div_run) begin
      div_cnt <= div_cnt - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      res_lcs  <= fin_lcs;
      res_dist <= fin_dist;
      sum      <= {1'b0, fin_lcs} + {1'b0, fin_dist};
      rem      <= '0;
      dvd      <= {fin_lcs, {FRAC_BITS{1'b0}}};
      quo      <= '0;
    end else if (cmd.div_run) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, sum}) begin
        rem <= rem_sub[SUM_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SUM_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  // Results; the quotient never exceeds 1.0 so its low bits carry it whole.
  assign res_empty = (sum == '0);
  assign res_sim   = res_empty ? '0 : quo[SIM_W-1:0];
  assign res_ovf   = overflow_seen;

endmodule

`default_nettype wire

// File: src/lcs_levenshtein_similarity.sv
// Top level of the LCS and edit-distance similarity block: controller,
// datapath and the result register. Depends on lcsld_pkg, lcsld_ctrl, lcsld_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item at a time. An append to the first string is taken without a stall.
// Appending to the second string sweeps the stored first string one cell per
// cycle through the row memories, and further items wait until the sweep ends.
// Finish reads the last row entry and runs a restoring divider of 25 steps at
// one quotient bit per cycle. The result is then loaded into the output register
// as soon as that register is free. A result that waits there does not hold back
// new items, but a second finish holds back further items until the first result
// has been transferred. Unused op codes are taken and do nothing. No clearing
// pass is needed after reset.
module lcs_levenshtein_similarity (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [lcsld_pkg::OP_W-1:0]       op,
  input  wire logic [lcsld_pkg::SYM_IN_W-1:0]   symbol,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [lcsld_pkg::LEN_W-1:0]           lcs_length,
  output logic [lcsld_pkg::LEN_W-1:0]           edit_distance,
  output logic [lcsld_pkg::SIM_W-1:0]           similarity,
  output logic                                  both_empty,
  output logic                                  overflow
);
  import lcsld_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic             out_free;
  logic             out_load;
  logic [LEN_W-1:0] res_lcs;
  logic [LEN_W-1:0] res_dist;
  logic [SIM_W-1:0] res_sim;
  logic             res_empty;
  logic             res_ovf;

  lcsld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .out_free (out_free),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  lcsld_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .symbol    (symbol),
    .cmd       (cmd),
    .status    (status),
    .res_lcs   (res_lcs),
    .res_dist  (res_dist),
    .res_sim   (res_sim),
    .res_empty (res_empty),
    .res_ovf   (res_ovf)
  );

  // The output register is free when empty or when its result transfers now.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, held while stalled.
  always_ff @(posedge clk) begin
    if (out_load) begin
      lcs_length    <= res_lcs;
      edit_distance <= res_dist;
      similarity    <= res_sim;
      both_empty    <= res_empty;
      overflow      <= res_ovf;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for lcs_levenshtein_similarity. It drives string symbols and
// finish transfers, and predicts LCS length, edit distance and similarity for each finish.
// Depends on lcsld_pkg and the RTL of lcs_levenshtein_similarity.
`timescale 1ns / 1ps

module testbench;
  import lcsld_pkg::*;

  // The op field has one code that the block does nothing with.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int TOTAL_ITEMS   = 1450;
  localparam int CALM_ITEMS    = 150;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 500;
  localparam int HOLD_AFTER    = 12;
  // Bound on the run length, so that a hung run ends with a fail message.
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic [OP_W-1:0]     code;
    logic [SYM_IN_W-1:0] sym;
    bit                  drain;
  } item_t;

  typedef struct {
    logic [LEN_W-1:0] lcs;
    logic [LEN_W-1:0] ld;
    logic [SIM_W-1:0] sim;
    logic             empty;
    logic             ovf;
  } score_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [OP_W-1:0]     op        = OP_UNUSED;
  logic [SYM_IN_W-1:0] symbol    = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [LEN_W-1:0]    lcs_length;
  logic [LEN_W-1:0]    edit_distance;
  logic [SIM_W-1:0]    similarity;
  logic                both_empty;
  logic                overflow;

  // Predictor state: the stored first string and the two rows.
  logic [SYM_W-1:0]    stored_syms [MAX_LEN];
  int                  lcs_cells [MAX_LEN+1];
  int                  dist_cells [MAX_LEN+1];
  int                  first_len;
  int                  second_len;
  bit                  dropped_seen;

  logic [SYM_IN_W-1:0] big_syms [MAX_LEN+1];
  item_t               pending_items[$];
  score_t              expected_scores[$];
  score_t              want;
  int                  errors = 0;
  int                  scores_checked = 0;
  int                  cycles = 0;
  bit                  tail_part = 1'b0;
  int                  in_gap = 0;
  int                  in_odds = 4;
  int                  out_gap = 0;
  int                  out_odds = 4;
  int                  hold_left = 0;
  bit                  hold_done = 1'b0;

  lcs_levenshtein_similarity dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .symbol        (symbol),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .lcs_length    (lcs_length),
    .edit_distance (edit_distance),
    .similarity    (similarity),
    .both_empty    (both_empty),
    .overflow      (overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Return the predictor to its state after reset or after a finish.
  function automatic void clear_strings();
    for (int i = 0; i <= MAX_LEN; i++) begin
      lcs_cells[i]  = 0;
      dist_cells[i] = i;
    end
    first_len    = 0;
    second_len   = 0;
    dropped_seen = 1'b0;
  endfunction

  // Advance both rows by one second-string symbol.
  function automatic void sweep_row(input logic [SYM_W-1:0] sym);
    int  diag_l;
    int  diag_d;
    int  up_l;
    int  up_d;
    int  best;
    bit  same;
    diag_l = lcs_cells[0];
    diag_d = dist_cells[0];
    lcs_cells[0]  = 0;
    dist_cells[0] = second_len + 1;
    for (int i = 1; i <= first_len; i++) begin
      up_l = lcs_cells[i];
      up_d = dist_cells[i];
      same = (stored_syms[i-1] == sym);
      if (same) begin
        lcs_cells[i] = diag_l + 1;
      end else begin
        lcs_cells[i] = (up_l > lcs_cells[i-1]) ? up_l : lcs_cells[i-1];
      end
      best = up_d + 1;
      if (dist_cells[i-1] + 1 < best) best = dist_cells[i-1] + 1;
      if (diag_d + (same ? 0 : 1) < best) best = diag_d + (same ? 0 : 1);
      dist_cells[i] = best;
      diag_l = up_l;
      diag_d = up_d;
    end
    second_len++;
  endfunction

  // Update the predictor with one accepted item; a finish queues its score.
  function automatic void apply_item(input logic [OP_W-1:0] code,
                                     input logic [SYM_IN_W-1:0] sym);
    score_t s;
    int     total;
    case (code)
      OP_FIRST: begin
        if (second_len == 0) begin
          if (first_len >= MAX_LEN) begin
            dropped_seen = 1'b1;
          end else begin
            stored_syms[first_len] = sym[SYM_W-1:0];
            first_len++;
            lcs_cells[first_len]  = 0;
            dist_cells[first_len] = first_len;
          end
        end
      end
      OP_SECOND: begin
        if (second_len >= MAX_LEN) begin
          dropped_seen = 1'b1;
        end else begin
          sweep_row(sym[SYM_W-1:0]);
        end
      end
      OP_FINISH: begin
        total   = lcs_cells[first_len] + dist_cells[first_len];
        s.lcs   = lcs_cells[first_len];
        s.ld    = dist_cells[first_len];
        s.empty = (total == 0);
        s.sim   = (total == 0) ? 0 : (lcs_cells[first_len] << FRAC_BITS) / total;
        s.ovf   = dropped_seen;
        expected_scores.insert(expected_scores.size(), s);
        clear_strings();
      end
      default: begin
      end
    endcase
  endfunction

  task automatic push_item(input logic [OP_W-1:0] code, input logic [SYM_IN_W-1:0] sym,
                           input bit drain);
    item_t it;
    it.code  = code;
    it.sym   = sym;
    it.drain = drain;
    pending_items.insert(pending_items.size(), it);
  endtask

  // A narrow alphabet makes common subsequences likely; otherwise any 16-bit code.
  function automatic logic [SYM_IN_W-1:0] pick_symbol(input bit narrow,
                                                      input logic [SYM_IN_W-1:0] base);
    if (narrow) begin
      return base + SYM_IN_W'($urandom_range(0, 3));
    end
    return SYM_IN_W'($urandom);
  endfunction

  // A short pair of strings and a finish, with some ignored items mixed in.
  task automatic add_random_pair();
    int                  n_first;
    int                  n_second;
    int                  span;
    int                  start;
    bit                  narrow;
    logic [SYM_IN_W-1:0] base;
    span     = ($urandom_range(0, 9) == 0) ? 30 : 8;
    n_first  = $urandom_range(0, span);
    n_second = $urandom_range(0, span);
    narrow   = ($urandom_range(0, 3) != 0);
    base     = SYM_IN_W'($urandom);
    start    = pending_items.size();
    for (int k = 0; k < n_first; k++) begin
      if ($urandom_range(0, 19) == 0) push_item(OP_UNUSED, SYM_IN_W'($urandom), 1'b0);
      push_item(OP_FIRST, pick_symbol(narrow, base), 1'b0);
    end
    for (int k = 0; k < n_second; k++) begin
      push_item(OP_SECOND, pick_symbol(narrow, base), 1'b0);
      // A first-string symbol after the second string has started is dropped.
      if ($urandom_range(0, 14) == 0) push_item(OP_FIRST, pick_symbol(narrow, base), 1'b0);
    end
    push_item(OP_FINISH, SYM_IN_W'($urandom), 1'b0);
    if ($urandom_range(0, 24) == 0) pending_items[start].drain = 1'b1;
  endtask

  // Driver: predicts each accepted transfer and offers the next item.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      tail_part <= (pending_items.size() < CALM_ITEMS);
      if (in_valid && !in_stall) apply_item(op, symbol);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain && expected_scores.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!tail_part && in_odds != 0 && $urandom_range(0, in_odds - 1) == 0) begin
          in_gap   = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          op       <= pending_items[0].code;
          symbol   <= pending_items[0].sym;
          void'(pending_items.pop_front());
          if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 2))
              0: in_odds = 0;
              1: in_odds = 3;
              default: in_odds = 8;
            endcase
          end
        end
      end
    end
  end

  task automatic check_field(input string name, input int expected_val, input int actual_val);
    if (expected_val != actual_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected_val,
               actual_val);
      errors++;
    end
  endtask

  // Monitor: checks each result transfer and drives the receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_scores.size() == 0) begin
          $display("%0t: result with no finish waiting, expected none, got lcs %0d dist %0d",
                   $time, lcs_length, edit_distance);
          errors++;
        end else begin
          want = expected_scores.pop_front();
          check_field("lcs_length", want.lcs, lcs_length);
          check_field("edit_distance", want.ld, edit_distance);
          check_field("similarity", want.sim, similarity);
          check_field("both_empty", want.empty, both_empty);
          check_field("overflow", want.ovf, overflow);
        end
        scores_checked++;
      end
      // One long hold-off, so that a second finish backs up into the input.
      if (!hold_done && scores_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!tail_part && out_odds != 0 && $urandom_range(0, out_odds - 1) == 0) begin
        out_gap   = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0: out_odds = 0;
            1: out_odds = 3;
            default: out_odds = 8;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lcs_levenshtein_similarity regression: fail");
      $finish;
    end
  end

  initial begin
    clear_strings();

    // Both strings empty, with an unused code between two finishes.
    push_item(OP_FINISH, 16'hFFFF, 1'b0);
    push_item(OP_UNUSED, 16'hA5A5, 1'b0);
    push_item(OP_FINISH, 16'h0000, 1'b0);
    // Identical one-symbol strings give similarity 1.0.
    push_item(OP_FIRST, 16'h0041, 1'b0);
    push_item(OP_SECOND, 16'h0041, 1'b0);
    push_item(OP_FINISH, 16'h5555, 1'b0);
    // Extreme symbol codes, one symbol missing from the second string.
    push_item(OP_FIRST, 16'h0000, 1'b0);
    push_item(OP_FIRST, 16'hFFFF, 1'b0);
    push_item(OP_SECOND, 16'hFFFF, 1'b0);
    push_item(OP_FINISH, 16'hAAAA, 1'b0);
    // Empty first string; the sender first waits for every result to arrive.
    push_item(OP_SECOND, 16'h1234, 1'b1);
    push_item(OP_SECOND, 16'h8000, 1'b0);
    push_item(OP_FINISH, 16'h0000, 1'b0);
    // Empty second string, with an unused code inside the pair.
    push_item(OP_FIRST, 16'h7FFF, 1'b0);
    push_item(OP_UNUSED, 16'h5A5A, 1'b0);
    push_item(OP_FIRST, 16'h0001, 1'b0);
    push_item(OP_FINISH, 16'h0000, 1'b0);
    // A first-string symbol after the second string has started is dropped.
    push_item(OP_FIRST, 16'h0042, 1'b0);
    push_item(OP_SECOND, 16'h0043, 1'b0);
    push_item(OP_FIRST, 16'h0043, 1'b0);
    push_item(OP_FINISH, 16'h0000, 1'b0);

    for (int p = 0; p < 20; p++) add_random_pair();

    // Identical full-length strings, each with one symbol past the limit.
    for (int k = 0; k <= MAX_LEN; k++) begin
      big_syms[k] = SYM_IN_W'($urandom);
      push_item(OP_FIRST, big_syms[k], 1'b0);
    end
    for (int k = 0; k <= MAX_LEN; k++) push_item(OP_SECOND, big_syms[k], 1'b0);
    push_item(OP_FINISH, 16'h0000, 1'b0);

    // Empty first string against an overlong second string.
    for (int k = 0; k <= MAX_LEN; k++) push_item(OP_SECOND, SYM_IN_W'($urandom), 1'b0);
    push_item(OP_FINISH, 16'hFFFF, 1'b0);

    while (pending_items.size() < TOTAL_ITEMS) add_random_pair();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || expected_scores.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("lcs_levenshtein_similarity regression: pass");
    end else begin
      $display("lcs_levenshtein_similarity regression: fail");
    end
    $finish;
  end

endmodule
